// ----- rtl/gne_pkg.sv -----
package gne_pkg;

    // Size of the wire store; indexes at or above it are flagged.
    localparam int NUM_WIRES = 65536;
    localparam int ADDR_W    = $clog2(NUM_WIRES);
    localparam int IDX_W     = 16;
    localparam int OP_W      = 3;

    localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
    localparam logic [OP_W-1:0] OP_XOR  = 3'd1;
    localparam logic [OP_W-1:0] OP_AND  = 3'd2;
    localparam logic [OP_W-1:0] OP_INV  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch request fields
        logic rd_a;      // read first source wire
        logic rd_b;      // read second source wire
        logic hold_a;    // keep first source bit
        logic wr;        // write the store
        logic emit;      // load result registers
    } gne_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic            range_err;
        logic [OP_W-1:0] op;
    } gne_stat_t;

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
        logic [31:0] ext;
        ext = 32'(idx);
        return (ext < 32'(NUM_WIRES));
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [31:0] ext;
        ext = 32'(idx);
        return ext[ADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/gate_netlist_evaluator.sv -----
// Gate netlist evaluator. Each request (start high while busy is low) is one
// operation on a store of NUM_WIRES one-bit wires: load a primary input bit,
// apply an XOR, AND or INV gate from source wires to a destination wire, or
// read a wire back. Requests are applied strictly in order, so a gate sees
// every earlier write. A read, or a load or gate that uses a wire index at
// or above NUM_WIRES, produces one result: result_valid pulses for exactly
// one cycle with wire_value and index_error, and there is no way to hold
// it off, so sample it on that cycle. An out-of-range request changes
// nothing and reports index_error high with wire_value low. Loads, in-range
// gates and unknown opcodes produce no result. The store sits in a single
// RAM with one read and one write port, so the request rate follows the
// number of reads: load, error and unknown-opcode requests read nothing,
// read and INV read one wire, XOR and AND read two. A result strobe
// appears on the cycle after the last step, the same cycle busy drops, so a
// new request can be issued while the result is shown. Wires are undefined
// until first written; reading one beforehand returns an arbitrary bit.
module gate_netlist_evaluator
    import gne_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [OP_W-1:0]  opcode,
    input  logic [IDX_W-1:0] first_wire,
    input  logic [IDX_W-1:0] second_wire,
    input  logic [IDX_W-1:0] dest_wire,
    input  logic             load_value,
    output logic             result_valid,
    output logic             wire_value,
    output logic             index_error
);

    gne_cmd_t  cmd;
    gne_stat_t stat;

    // sequencing: decode, one or two store reads, write back or report
    gne_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd),
        .stat         (stat)
    );

    // request latch, range check, gate logic and the wire store
    gne_datapath u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .first_wire  (first_wire),
        .second_wire (second_wire),
        .dest_wire   (dest_wire),
        .load_value  (load_value),
        .wire_value  (wire_value),
        .index_error (index_error)
    );

endmodule

// ----- rtl/gne_ram.sv -----
module gne_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/gne_datapath.sv -----
module gne_datapath
    import gne_pkg::*;
(
    input  logic             clk,
    input  gne_cmd_t         cmd,
    output gne_stat_t        stat,
    input  logic [OP_W-1:0]  opcode,
    input  logic [IDX_W-1:0] first_wire,
    input  logic [IDX_W-1:0] second_wire,
    input  logic [IDX_W-1:0] dest_wire,
    input  logic             load_value,
    output logic             wire_value,
    output logic             index_error
);

    logic [OP_W-1:0]  op_reg;
    logic [IDX_W-1:0] a_reg;
    logic [IDX_W-1:0] b_reg;
    logic [IDX_W-1:0] d_reg;
    logic             lv_reg;
    logic             a_bit_reg;
    logic             wire_value_reg;
    logic             index_error_reg;

    logic              range_err;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= opcode;
            a_reg  <= first_wire;
            b_reg  <= second_wire;
            d_reg  <= dest_wire;
            lv_reg <= load_value;
        end
        if (cmd.hold_a)
        begin
            a_bit_reg <= ram_rdata;
        end
        if (cmd.emit)
        begin
            wire_value_reg  <= range_err ? 1'b0 : ram_rdata;
            index_error_reg <= range_err;
        end
    end

    // which indexes each operation touches
    always_comb
    begin
        unique case (op_reg)
            OP_LOAD, OP_READ: range_err = !idx_ok(a_reg);
            OP_XOR, OP_AND:   range_err = !idx_ok(a_reg) || !idx_ok(b_reg) || !idx_ok(d_reg);
            OP_INV:           range_err = !idx_ok(a_reg) || !idx_ok(d_reg);
            default:          range_err = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (op_reg)
            OP_LOAD: ram_wdata = lv_reg;
            OP_XOR:  ram_wdata = a_bit_reg ^ ram_rdata;
            OP_AND:  ram_wdata = a_bit_reg & ram_rdata;
            OP_INV:  ram_wdata = ~ram_rdata;
            default: ram_wdata = 1'b0;
        endcase
    end

    assign ram_we    = cmd.wr;
    assign ram_waddr = (op_reg == OP_LOAD) ? to_addr(a_reg) : to_addr(d_reg);
    assign ram_re    = cmd.rd_a | cmd.rd_b;
    assign ram_raddr = cmd.rd_b ? to_addr(b_reg) : to_addr(a_reg);

    gne_ram #(
        .WIDTH (1),
        .DEPTH (NUM_WIRES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.range_err = range_err;
    assign stat.op        = op_reg;
    assign wire_value     = wire_value_reg;
    assign index_error    = index_error_reg;

endmodule

// ----- rtl/gne_ctrl.sv -----
module gne_ctrl
    import gne_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      result_valid,
    output gne_cmd_t  cmd,
    input  gne_stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SECOND,
        S_COMBINE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        cmd               = '0;
        state_next        = state_reg;
        result_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                if (stat.range_err)
                begin
                    cmd.emit          = 1'b1;
                    result_valid_next = 1'b1;
                end
                else
                begin
                    unique case (stat.op)
                        OP_LOAD:
                        begin
                            cmd.wr = 1'b1;
                        end
                        OP_XOR, OP_AND, OP_INV, OP_READ:
                        begin
                            cmd.rd_a   = 1'b1;
                            state_next = S_SECOND;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SECOND:
            begin
                // first source bit is on the RAM output now
                state_next = S_IDLE;
                unique case (stat.op)
                    OP_READ:
                    begin
                        cmd.emit          = 1'b1;
                        result_valid_next = 1'b1;
                    end
                    OP_INV:
                    begin
                        cmd.wr = 1'b1;
                    end
                    default:
                    begin
                        cmd.hold_a = 1'b1;
                        cmd.rd_b   = 1'b1;
                        state_next = S_COMBINE;
                    end
                endcase
            end
            S_COMBINE:
            begin
                cmd.wr     = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

endmodule

// ----- rtl/gne_checker.sv -----
module gne_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input logic wire_value,
    input logic index_error
);

    // an error result never carries a wire bit
    ast_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(wire_value && index_error))
        else $error("error result with wire_value set");

    // an accepted request always makes the block busy in the next cycle
    ast_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");

    // a result closes its request
    ast_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while still busy");

    // no result appears without a request in flight
    ast_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !result_valid)
        else $error("result without request");

    // no two results come back to back
    ast_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind gate_netlist_evaluator gne_checker u_gne_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .wire_value   (wire_value),
    .index_error  (index_error)
);

// ----- test/gate_netlist_evaluator_tb.sv -----
`timescale 1ns / 1ps

module gate_netlist_evaluator_tb;
    import gne_pkg::*;

    localparam int ITEMS          = 1950;  // random requests that do real work
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request or result accepted
    localparam int DRAIN_CYCLES   = 8;     // margin for stray results after the last owed one
    localparam int IDX_MAX        = (1 << IDX_W) - 1;
    localparam int OP_MAX         = (1 << OP_W) - 1;

    typedef struct packed {
        logic wire_value;
        logic index_error;
    } wire_result_t;

    // Shadow copy of the wire store plus the queue of results still owed by
    // the block. Also tracks which wires were written, so that stimulus never
    // reads a wire that is still undefined.
    class netlist_scoreboard;
        bit               wire_bits [NUM_WIRES];
        bit               written [NUM_WIRES];
        logic [IDX_W-1:0] written_wires [$];
        logic [IDX_W-1:0] last_write;
        wire_result_t     due_results [$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      op_seen [OP_MAX+1];

        function bit in_store(logic [IDX_W-1:0] idx);
            return int'(idx) < NUM_WIRES;
        endfunction

        function void set_wire(logic [IDX_W-1:0] idx, bit v);
            wire_bits[idx] = v;
            last_write     = idx;
            if (!written[idx])
            begin
                written[idx] = 1'b1;
                written_wires.push_back(idx);
            end
        endfunction

        function void flag_index();
            wire_result_t res;
            res.wire_value  = 1'b0;
            res.index_error = 1'b1;
            due_results.push_back(res);
        endfunction

        // Apply one accepted request in order; queue the result if it has one.
        function void apply_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] a,
                                    logic [IDX_W-1:0] b, logic [IDX_W-1:0] d,
                                    logic v);
            wire_result_t res;
            op_seen[op]++;
            case (op)
                OP_LOAD:
                    if (!in_store(a)) flag_index();
                    else set_wire(a, v);
                OP_XOR, OP_AND:
                    if (!in_store(a) || !in_store(b) || !in_store(d)) flag_index();
                    else if (op == OP_XOR) set_wire(d, wire_bits[a] ^ wire_bits[b]);
                    else set_wire(d, wire_bits[a] & wire_bits[b]);
                OP_INV:
                    if (!in_store(a) || !in_store(d)) flag_index();
                    else set_wire(d, !wire_bits[a]);
                OP_READ:
                    if (!in_store(a)) flag_index();
                    else
                    begin
                        res.wire_value  = wire_bits[a];
                        res.index_error = 1'b0;
                        due_results.push_back(res);
                    end
                default: ;  // unused opcodes are dropped
            endcase
        endfunction

        function void check_result(logic value, logic err);
            wire_result_t exp;
            if (due_results.size() == 0)
            begin
                $display("%0t: result with none expected: wire_value=%b index_error=%b",
                         $time, value, err);
                errors++;
                return;
            end
            exp = due_results.pop_front();
            checked++;
            if (value !== exp.wire_value)
            begin
                $display("%0t: wire_value mismatch: expected %b, actual %b",
                         $time, exp.wire_value, value);
                errors++;
            end
            if (err !== exp.index_error)
            begin
                $display("%0t: index_error mismatch: expected %b, actual %b",
                         $time, exp.index_error, err);
                errors++;
            end
        endfunction

        // Source wire for a gate or a read: biased toward recent writes so
        // that back-to-back dependencies show up often.
        function logic [IDX_W-1:0] pick_written();
            int unsigned n;
            n = written_wires.size();
            case ($urandom_range(0, 3))
                0:       return last_write;
                1:       if (n > 4) return written_wires[n - 1 - $urandom_range(0, 3)];
                default: ;
            endcase
            return written_wires[$urandom_range(0, n - 1)];
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] first_wire;
    logic [IDX_W-1:0] second_wire;
    logic [IDX_W-1:0] dest_wire;
    logic             load_value;
    logic             result_valid;
    logic             wire_value;
    logic             index_error;

    netlist_scoreboard sb = new;
    int unsigned       idle_cycles;

    gate_netlist_evaluator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .first_wire   (first_wire),
        .second_wire  (second_wire),
        .dest_wire    (dest_wire),
        .load_value   (load_value),
        .result_valid (result_valid),
        .wire_value   (wire_value),
        .index_error  (index_error)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Results cannot be held off; take each one on its strobe cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(wire_value, index_error);
    end

    // Watchdog: any accepted request or result restarts the count.
    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || result_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance,
    // with start still high so the next request can follow without a gap.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] a,
                                input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] d,
                                input logic v);
        start       = 1'b1;
        opcode      = op;
        first_wire  = a;
        second_wire = b;
        dest_wire   = d;
        load_value  = v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.apply_request(op, a, b, d, v);
        @(negedge clk);
    endtask

    // Sender gap; fields carry junk while start is low.
    task automatic pause(input int unsigned cycles);
        start = 1'b0;
        repeat (cycles)
        begin
            opcode      = OP_W'($urandom_range(0, OP_MAX));
            first_wire  = IDX_W'($urandom_range(0, IDX_MAX));
            second_wire = IDX_W'($urandom_range(0, IDX_MAX));
            dest_wire   = IDX_W'($urandom_range(0, IDX_MAX));
            load_value  = 1'($urandom_range(0, 1));
            @(negedge clk);
        end
    endtask

    // One random request. Mostly well-formed gate traffic over written wires;
    // a small share of unused opcodes as noise (those are not counted).
    task automatic random_request(output bit counted);
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] d;
        logic             v;
        int unsigned      pick;
        pick    = $urandom_range(0, 99);
        a       = IDX_W'($urandom_range(0, IDX_MAX));
        b       = IDX_W'($urandom_range(0, IDX_MAX));
        d       = IDX_W'($urandom_range(0, IDX_MAX));
        v       = 1'($urandom_range(0, 1));
        counted = 1'b1;
        if (pick < 15)
        begin
            op = OP_LOAD;
            if ($urandom_range(0, 4) == 0)
                a = sb.pick_written();
        end
        else if (pick < 95)
        begin
            if (pick < 35)
                op = OP_XOR;
            else if (pick < 55)
                op = OP_AND;
            else if (pick < 70)
                op = OP_INV;
            else
                op = OP_READ;
            a = sb.pick_written();
            if (op == OP_XOR || op == OP_AND)
                b = sb.pick_written();
            // half the gates overwrite a live wire, sometimes their own source
            if (op != OP_READ && $urandom_range(0, 1) == 0)
                d = ($urandom_range(0, 3) == 0) ? a : sb.pick_written();
        end
        else
        begin
            op      = OP_W'($urandom_range(OP_READ + 1, OP_MAX));
            counted = 1'b0;
        end
        send_request(op, a, b, d, v);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned burst;
        bit          counted;

        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = OP_LOAD;
        first_wire  = '0;
        second_wire = '0;
        dest_wire   = '0;
        load_value  = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: primary inputs at the ends and the string boundaries,
        // every gate, in-place gates and reads right after writes.
        send_request(OP_LOAD, 16'd0,      16'd0,      16'd0,      1'b0);
        send_request(OP_LOAD, 16'hFFFF,   16'hFFFF,   16'hFFFF,   1'b1);
        send_request(OP_LOAD, 16'd63,     16'd0,      16'd0,      1'b1);
        send_request(OP_LOAD, 16'd64,     16'd0,      16'd0,      1'b0);
        send_request(OP_LOAD, 16'd127,    16'd0,      16'd0,      1'b1);
        send_request(OP_LOAD, 16'd48,     16'd0,      16'd0,      1'b1);
        send_request(OP_LOAD, 16'h5555,   16'hAAAA,   16'h5555,   1'b1);
        send_request(OP_LOAD, 16'hAAAA,   16'h5555,   16'hAAAA,   1'b0);
        send_request(OP_READ, 16'd0,      16'hFFFF,   16'hFFFF,   1'b1);
        send_request(OP_READ, 16'hFFFF,   16'd0,      16'd0,      1'b0);
        send_request(OP_XOR,  16'd63,     16'd64,     16'd127,    1'b0);
        send_request(OP_READ, 16'd127,    16'd0,      16'd0,      1'b0);
        send_request(OP_AND,  16'hFFFF,   16'h5555,   16'd200,    1'b1);
        send_request(OP_AND,  16'd200,    16'hFFFF,   16'hAAAA,   1'b0);
        send_request(OP_READ, 16'hAAAA,   16'd0,      16'd0,      1'b0);
        send_request(OP_INV,  16'd0,      16'hFFFF,   16'd0,      1'b1);
        send_request(OP_READ, 16'd0,      16'd0,      16'd0,      1'b0);
        send_request(OP_XOR,  16'd48,     16'd48,     16'd48,     1'b1);
        send_request(OP_XOR,  16'd48,     16'hFFFF,   16'h5555,   1'b0);
        send_request(OP_READ, 16'h5555,   16'd0,      16'd0,      1'b0);
        send_request(OP_INV,  16'd64,     16'hFFFF,   16'hFFFF,   1'b0);
        send_request(OP_READ, 16'hFFFF,   16'd0,      16'd0,      1'b0);
        send_request(OP_W'(OP_MAX), 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_request(OP_W'(OP_READ + 1), 16'd0, 16'd0, 16'd0, 1'b0);
        send_request(OP_READ, 16'd48,     16'd0,      16'd0,      1'b0);
        pause(3);

        // Random bursts; about a quarter of them run on with no gap after.
        sent = 0;
        while (sent < ITEMS)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                random_request(counted);
                if (counted)
                    sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 8));
        end
        pause(1);

        // Drain: all owed results, then a few cycles for strays.
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d loads, %0d xor, %0d and, %0d inv, %0d reads",
                 sb.op_seen[OP_LOAD], sb.op_seen[OP_XOR], sb.op_seen[OP_AND],
                 sb.op_seen[OP_INV], sb.op_seen[OP_READ]);
        $display("%0d unused opcodes sent, %0d results checked over %0d wires written",
                 sb.op_seen[OP_READ+1] + sb.op_seen[OP_READ+2] + sb.op_seen[OP_READ+3],
                 sb.checked, sb.written_wires.size());
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
